// ----- src/ddsc_pkg.sv -----
// Shared types, constants and the command sequence for the stepper controller.
// No dependencies; every other file imports this package.
`default_nettype none
package ddsc_pkg;

    // Timer and divider sizing
    localparam int TIMER_BITS = 32;
    localparam int DIV_N = 32;
    localparam int DIV_D = 26;
    localparam int CNT_W = $clog2(DIV_N);

    localparam logic [TIMER_BITS-1:0] ZERO_PERIOD = TIMER_BITS'(1000000);
    localparam logic [DIV_N-1:0] TICK_SCALE = DIV_N'(256000000);

    // Wheel conversion: (5625*v -/+ 440*w) / 2826 in Q7.8
    localparam logic signed [31:0] WHEEL_V_GAIN = 32'sd5625;
    localparam logic signed [31:0] WHEEL_W_GAIN = 32'sd440;

    // Division by 2826 is a multiply by the rounded-up value of 2^40/2826 and a
    // shift by 40; the quotient is exact for numerators below 2^28.
    localparam int WHEEL_SHIFT = 40;
    localparam logic [28:0] WHEEL_RECIP = 29'd389069932;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_VEL  = 2'd1,
        REQ_RPS  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_VMAX  = 2'd0,
        CFG_WMAX  = 2'd1,
        CFG_RMAX  = 2'd2,
        CFG_STEPS = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_TICK, OP_LOAD_RPS,
        OP_DIV_BA, OP_FIN_BA, OP_DIV_AB, OP_FIN_AB, OP_HELD,
        OP_MUL_V, OP_MUL_W, OP_DIV_L, OP_FIN_L, OP_DIV_R, OP_FIN_R,
        OP_MAX, OP_DIV_LL, OP_FIN_LL, OP_DIV_LR, OP_FIN_LR, OP_COMMIT,
        OP_PMUL_L, OP_PDIV_L, OP_PFIN_L, OP_PMUL_R, OP_PDIV_R, OP_PFIN_R
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    // Command sequence: rps commands start at entry zero, velocity commands at one
    localparam int PROG_LEN = 24;
    localparam int PROG_W = $clog2(PROG_LEN);
    localparam logic [PROG_W-1:0] IDX_RPS = PROG_W'(0);
    localparam logic [PROG_W-1:0] IDX_VEL = PROG_W'(1);
    localparam logic [PROG_W-1:0] IDX_MAX = PROG_W'(12);
    localparam logic [PROG_W-1:0] IDX_LAST = PROG_W'(PROG_LEN - 1);

    function automatic dp_op_t prog_op(input logic [PROG_W-1:0] idx);
        dp_op_t op;
        case (idx)
            5'd0:    op = OP_LOAD_RPS;
            5'd1:    op = OP_DIV_BA;
            5'd2:    op = OP_FIN_BA;
            5'd3:    op = OP_DIV_AB;
            5'd4:    op = OP_FIN_AB;
            5'd5:    op = OP_HELD;
            5'd6:    op = OP_MUL_V;
            5'd7:    op = OP_MUL_W;
            5'd8:    op = OP_DIV_L;
            5'd9:    op = OP_FIN_L;
            5'd10:   op = OP_DIV_R;
            5'd11:   op = OP_FIN_R;
            5'd12:   op = OP_MAX;
            5'd13:   op = OP_DIV_LL;
            5'd14:   op = OP_FIN_LL;
            5'd15:   op = OP_DIV_LR;
            5'd16:   op = OP_FIN_LR;
            5'd17:   op = OP_COMMIT;
            5'd18:   op = OP_PMUL_L;
            5'd19:   op = OP_PDIV_L;
            5'd20:   op = OP_PFIN_L;
            5'd21:   op = OP_PMUL_R;
            5'd22:   op = OP_PDIV_R;
            5'd23:   op = OP_PFIN_R;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    // Operations that start the shared divider and wait for it
    function automatic logic op_is_div(input dp_op_t op);
        return (op == OP_DIV_BA) || (op == OP_DIV_AB) ||
               (op == OP_DIV_LL) || (op == OP_DIV_LR) ||
               (op == OP_PDIV_L) || (op == OP_PDIV_R);
    endfunction

    // Half-step coil patterns for phases one to eight
    function automatic logic [3:0] coil_for(input logic [3:0] phase);
        logic [3:0] c;
        case (phase)
            4'd1:    c = 4'h1;
            4'd2:    c = 4'h5;
            4'd3:    c = 4'h4;
            4'd4:    c = 4'h6;
            4'd5:    c = 4'h2;
            4'd6:    c = 4'hA;
            4'd7:    c = 4'h8;
            4'd8:    c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- src/diff_drive_stepper_controller_unit.sv -----
// Two-motor half-step stepper controller, top level: controller plus datapath.
// A tick word passes through the tick and done states into the output register.
// Rps commands make four passes of the shared divider; velocity commands also
// divide for the speed and turn limits. The wheel conversion is a constant multiply.
// One word is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset restores register defaults, stops both motors, phases one.
`default_nettype none
module diff_drive_stepper_controller_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cmd_a[15:0], cmd_b[31:16]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // left_coils[3:0], right_coils[7:4], left_stepped[8], right_stepped[9],
    // left_rps_now[25:10], right_rps_now[41:26], speed_now[57:42],
    // turn_now[73:58], zero fill[79:74]
    output logic [79:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [14:0] cfg_wdata
);
    import ddsc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ddsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ddsc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ----- src/ddsc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, for limits and periods.
// Depends on ddsc_pkg for its widths.
`default_nettype none
module ddsc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ddsc_pkg::DIV_N-1:0] dividend,
    input  wire logic [ddsc_pkg::DIV_D-1:0] divisor,
    output logic                            done,
    output logic [ddsc_pkg::DIV_N-1:0]      quotient
);
    import ddsc_pkg::*;

    logic [DIV_D-1:0] rem_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DIV_D-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_D:0]   rem_sh;
    logic             ge;
    logic [DIV_D-1:0] rem_next;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_N-1]};
        ge = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? DIV_D'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIV_D-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_N-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/ddsc_datapath.sv -----
// Datapath: configuration, command limiting, wheel speeds, periods, step timers.
// Depends on ddsc_pkg and instantiates ddsc_div.
`default_nettype none
module ddsc_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ddsc_pkg::dp_cmd_t cmd,
    output ddsc_pkg::dp_stat_t     stat,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [14:0]       cfg_wdata,
    input  wire logic [31:0]       s_tdata,
    output logic [79:0]            m_tdata
);
    import ddsc_pkg::*;

    // Configuration registers
    logic [14:0] vmax_reg, wmax_reg, rmax_reg;
    logic [10:0] steps_reg;
    logic [10:0] st_eff;

    // Working registers
    logic signed [16:0] a_reg, b_reg;
    logic signed [31:0] sv_reg, tw_reg;
    logic signed [17:0] l_reg, r_reg;
    logic [16:0]        m_reg;
    logic [DIV_D-1:0]   pm_reg;
    logic               neg_reg;
    logic [27:0]        wm_reg;
    logic               wneg_reg;

    // Architectural state
    logic [3:0]            left_phase_reg, right_phase_reg;
    logic [TIMER_BITS-1:0] left_elapsed_reg, right_elapsed_reg;
    logic [TIMER_BITS-1:0] left_period_reg, right_period_reg;
    logic signed [15:0]    left_rps_reg, right_rps_reg;
    logic [15:0]           speed_held_reg, turn_held_reg;
    logic [3:0]            left_coil_reg, right_coil_reg;
    logic                  left_stepped_reg, right_stepped_reg;
    logic [79:0]           out_reg;

    // Divider connection
    logic             div_start, div_done, div_neg;
    logic [DIV_N-1:0] div_dvd, div_q;
    logic [DIV_D-1:0] div_dvs;

    logic [16:0]        mag_a, mag_b, mag_l, mag_r;
    logic signed [31:0] num_l, num_r;
    logic [15:0]        mag_lrps, mag_rrps;
    logic signed [16:0] qs17;
    logic signed [17:0] qs18;
    logic [WHEEL_SHIFT+16:0] wprod;
    logic signed [17:0]      ws18;
    logic [TIMER_BITS-1:0] le_inc, re_inc;

    function automatic logic [16:0] mag17(input logic signed [16:0] x);
        return x[16] ? 17'(-x) : 17'(x);
    endfunction

    function automatic logic [16:0] mag18(input logic signed [17:0] x);
        return x[17] ? 17'(-x) : 17'(x);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        return x[15] ? 16'(-x) : 16'(x);
    endfunction

    function automatic logic [3:0] step_phase(input logic [3:0] p, input logic down);
        logic [3:0] n;
        if (down) begin
            n = (p <= 4'd1) ? 4'd8 : p - 4'd1;
        end else begin
            n = (p >= 4'd8) ? 4'd1 : p + 4'd1;
        end
        return n;
    endfunction

    // Magnitudes, sums and signed quotients
    always_comb begin
        st_eff = (steps_reg == 11'd0) ? 11'd1 : steps_reg;
        mag_a = mag17(a_reg);
        mag_b = mag17(b_reg);
        mag_l = mag18(l_reg);
        mag_r = mag18(r_reg);
        num_l = sv_reg - tw_reg;
        num_r = sv_reg + tw_reg;
        mag_lrps = mag16(left_rps_reg);
        mag_rrps = mag16(right_rps_reg);
        qs17 = neg_reg ? -signed'(div_q[16:0]) : signed'(div_q[16:0]);
        qs18 = neg_reg ? -signed'({1'b0, div_q[16:0]}) : signed'({1'b0, div_q[16:0]});
        // Wheel speed quotient by reciprocal multiplication, sign applied after
        wprod = (WHEEL_SHIFT+17)'(wm_reg) * (WHEEL_SHIFT+17)'(WHEEL_RECIP);
        ws18 = wneg_reg ? -signed'({1'b0, wprod[WHEEL_SHIFT+16:WHEEL_SHIFT]})
                        : signed'({1'b0, wprod[WHEEL_SHIFT+16:WHEEL_SHIFT]});
        le_inc = (&left_elapsed_reg) ? left_elapsed_reg : left_elapsed_reg + 1'b1;
        re_inc = (&right_elapsed_reg) ? right_elapsed_reg : right_elapsed_reg + 1'b1;
    end

    // Divider operand selection for each division step
    always_comb begin
        div_start = op_is_div(cmd.op);
        div_dvd = '0;
        div_dvs = '0;
        div_neg = 1'b0;
        case (cmd.op)
            OP_DIV_BA: begin
                div_dvd = 32'(mag_b) * 32'(vmax_reg);
                div_dvs = DIV_D'(mag_a);
                div_neg = b_reg[16];
            end
            OP_DIV_AB: begin
                div_dvd = 32'(mag_a) * 32'(wmax_reg);
                div_dvs = DIV_D'(mag_b);
                div_neg = a_reg[16];
            end
            OP_DIV_LL: begin
                div_dvd = 32'(mag_l) * 32'(rmax_reg);
                div_dvs = DIV_D'(m_reg);
                div_neg = l_reg[17];
            end
            OP_DIV_LR: begin
                div_dvd = 32'(mag_r) * 32'(rmax_reg);
                div_dvs = DIV_D'(m_reg);
                div_neg = r_reg[17];
            end
            OP_PDIV_L, OP_PDIV_R: begin
                div_dvd = TICK_SCALE;
                div_dvs = pm_reg;
            end
            default: begin
                div_dvd = '0;
            end
        endcase
    end

    ddsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.div_done = div_done;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmax_reg  <= 15'd410;
            wmax_reg  <= 15'd5760;
            rmax_reg  <= 15'd1024;
            steps_reg <= 11'd50;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_VMAX:  vmax_reg  <= cfg_wdata;
                CFG_WMAX:  wmax_reg  <= cfg_wdata;
                CFG_RMAX:  rmax_reg  <= cfg_wdata;
                CFG_STEPS: steps_reg <= cfg_wdata[10:0];
                default:   vmax_reg  <= vmax_reg;
            endcase
        end
    end

    // Working registers for command processing
    always_ff @(posedge aclk) begin
        if (div_start) begin
            neg_reg <= div_neg;
        end
        if (cmd.capture) begin
            a_reg <= 17'(signed'(s_tdata[15:0]));
            b_reg <= 17'(signed'(s_tdata[31:16]));
        end
        case (cmd.op)
            OP_LOAD_RPS: begin
                l_reg <= 18'(a_reg);
                r_reg <= 18'(b_reg);
            end
            OP_FIN_BA: begin
                if (mag_a > {2'b00, vmax_reg}) begin
                    b_reg <= qs17;
                    a_reg <= a_reg[16] ? -signed'({2'b00, vmax_reg})
                                       : signed'({2'b00, vmax_reg});
                end
            end
            OP_FIN_AB: begin
                if (mag_b > {2'b00, wmax_reg}) begin
                    a_reg <= qs17;
                    b_reg <= b_reg[16] ? -signed'({2'b00, wmax_reg})
                                       : signed'({2'b00, wmax_reg});
                end
            end
            OP_MUL_V:  sv_reg <= 32'(a_reg) * WHEEL_V_GAIN;
            OP_MUL_W:  tw_reg <= 32'(b_reg) * WHEEL_W_GAIN;
            OP_DIV_L: begin
                wm_reg   <= 28'(mag32(num_l));
                wneg_reg <= num_l[31];
            end
            OP_DIV_R: begin
                wm_reg   <= 28'(mag32(num_r));
                wneg_reg <= num_r[31];
            end
            OP_FIN_L:  l_reg <= ws18;
            OP_FIN_R:  r_reg <= ws18;
            OP_MAX:    m_reg <= (mag_l > mag_r) ? mag_l : mag_r;
            OP_FIN_LL: begin
                if (m_reg > {2'b00, rmax_reg}) begin
                    l_reg <= qs18;
                end
            end
            OP_FIN_LR: begin
                if (m_reg > {2'b00, rmax_reg}) begin
                    r_reg <= qs18;
                end
            end
            OP_PMUL_L: pm_reg <= DIV_D'(32'(mag_lrps) * 32'(st_eff));
            OP_PMUL_R: pm_reg <= DIV_D'(32'(mag_rrps) * 32'(st_eff));
            default:   pm_reg <= pm_reg;
        endcase
    end

    // Block state: held command, wheel speeds, periods and step timers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_phase_reg    <= 4'd1;
            right_phase_reg   <= 4'd1;
            left_elapsed_reg  <= '0;
            right_elapsed_reg <= '0;
            left_period_reg   <= ZERO_PERIOD;
            right_period_reg  <= ZERO_PERIOD;
            left_rps_reg      <= '0;
            right_rps_reg     <= '0;
            speed_held_reg    <= '0;
            turn_held_reg     <= '0;
            left_coil_reg     <= '0;
            right_coil_reg    <= '0;
            left_stepped_reg  <= 1'b0;
            right_stepped_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                left_stepped_reg  <= 1'b0;
                right_stepped_reg <= 1'b0;
            end
            case (cmd.op)
                OP_HELD: begin
                    speed_held_reg <= a_reg[15:0];
                    turn_held_reg  <= b_reg[15:0];
                end
                OP_COMMIT: begin
                    left_rps_reg  <= l_reg[15:0];
                    right_rps_reg <= r_reg[15:0];
                end
                OP_PFIN_L: begin
                    left_period_reg <= (left_rps_reg == 16'sd0) ? ZERO_PERIOD
                                                                : TIMER_BITS'(div_q);
                end
                OP_PFIN_R: begin
                    right_period_reg <= (right_rps_reg == 16'sd0) ? ZERO_PERIOD
                                                                  : TIMER_BITS'(div_q);
                end
                OP_TICK: begin
                    // Left side counts down for negative speed
                    if (left_rps_reg == 16'sd0) begin
                        left_elapsed_reg <= le_inc;
                        left_coil_reg    <= 4'h0;
                        left_period_reg  <= ZERO_PERIOD;
                    end else if (le_inc > left_period_reg) begin
                        left_elapsed_reg <= '0;
                        left_coil_reg    <= coil_for(left_phase_reg);
                        left_phase_reg   <= step_phase(left_phase_reg, left_rps_reg[15]);
                        left_stepped_reg <= 1'b1;
                    end else begin
                        left_elapsed_reg <= le_inc;
                    end
                    // Right side counts down for positive speed
                    if (right_rps_reg == 16'sd0) begin
                        right_elapsed_reg <= re_inc;
                        right_coil_reg    <= 4'h0;
                        right_period_reg  <= ZERO_PERIOD;
                    end else if (re_inc > right_period_reg) begin
                        right_elapsed_reg <= '0;
                        right_coil_reg    <= coil_for(right_phase_reg);
                        right_phase_reg   <= step_phase(right_phase_reg,
                                                        !right_rps_reg[15]);
                        right_stepped_reg <= 1'b1;
                    end else begin
                        right_elapsed_reg <= re_inc;
                    end
                end
                default: begin
                    left_phase_reg <= left_phase_reg;
                end
            endcase
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= {6'b0, turn_held_reg, speed_held_reg, right_rps_reg,
                        left_rps_reg, right_stepped_reg, left_stepped_reg,
                        right_coil_reg, left_coil_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

// ----- src/ddsc_ctrl.sv -----
// Controller: handshakes and sequencing of datapath operations.
// Depends on ddsc_pkg for the command sequence and command types.
`default_nettype none
module ddsc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output ddsc_pkg::dp_cmd_t       cmd,
    input  wire ddsc_pkg::dp_stat_t stat
);
    import ddsc_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_TICK, ST_RUN, ST_WAIT, ST_DONE} state_t;

    state_t            state_reg;
    logic [PROG_W-1:0] idx_reg;
    logic              m_tvalid_reg;
    dp_op_t            cur_op;

    // Command decode
    always_comb begin
        cur_op = prog_op(idx_reg);
        cmd.op = OP_NOP;
        cmd.capture = 1'b0;
        cmd.out_load = 1'b0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_TICK: cmd.op = OP_TICK;
            ST_RUN:  cmd.op = cur_op;
            ST_DONE: cmd.out_load = !m_tvalid_reg || m_tready;
            default: cmd.op = OP_NOP;
        endcase
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        case (s_tuser)
                            REQ_TICK: state_reg <= ST_TICK;
                            REQ_VEL: begin
                                idx_reg   <= IDX_VEL;
                                state_reg <= ST_RUN;
                            end
                            REQ_RPS: begin
                                idx_reg   <= IDX_RPS;
                                state_reg <= ST_RUN;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_TICK: state_reg <= ST_DONE;
                ST_RUN: begin
                    if (op_is_div(cur_op)) begin
                        state_reg <= ST_WAIT;
                    end else if (cur_op == OP_LOAD_RPS) begin
                        idx_reg <= IDX_MAX;
                    end else if (idx_reg == IDX_LAST) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (stat.div_done) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_DONE: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for diff_drive_stepper_controller_unit: directed and random words,
// a cycle-free predictor of the controller and an in-order result checker.
// Depends on ddsc_pkg and the top level of the block only.
module tb;
    import ddsc_pkg::*;

    typedef struct packed {
        logic [5:0]         pad;
        logic signed [15:0] turn_now;
        logic signed [15:0] speed_now;
        logic signed [15:0] right_rps_now;
        logic signed [15:0] left_rps_now;
        logic               right_stepped;
        logic               left_stepped;
        logic [3:0]         right_coils;
        logic [3:0]         left_coils;
    } status_word_t;

    localparam longint COUNT_MAX = 64'hFFFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [14:0] cfg_wdata;

    diff_drive_stepper_controller_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Mirror of the controller state
    longint      vmax_q, wmax_q, rmax_q, steps_q;
    logic [3:0]  phase_l, phase_r, coil_l, coil_r;
    longint      elapsed_l, elapsed_r, period_l, period_r;
    longint      rps_l, rps_r, speed_q, turn_q;

    status_word_t expected_status[$];
    int          mismatches;
    int          words_sent, results_seen, steps_seen, commands_sent;
    int          burst_left;
    int          stall_left;
    int          calm_cnt;

    logic [3:0]  half_step_coils [0:15] = '{4'h0, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA,
                                            4'h8, 4'h9, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
                                            4'h0, 4'h0};

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint step_period(input longint rps);
        longint st;
        st = (steps_q != 0) ? steps_q : 1;
        if (rps == 0) return 1000000;
        return 256000000 / (magnitude(rps) * st);
    endfunction

    // Scale both wheel speeds together into the rps limit.
    function automatic void load_wheel_speeds(input longint l, input longint r);
        longint m;
        m = (magnitude(l) > magnitude(r)) ? magnitude(l) : magnitude(r);
        if (m > rmax_q) begin
            l = l * rmax_q / m;
            r = r * rmax_q / m;
        end
        rps_l = l;
        rps_r = r;
        period_l = step_period(l);
        period_r = step_period(r);
    endfunction

    function automatic logic [3:0] advance_phase(input logic [3:0] p, input logic down);
        if (down) return (p <= 1) ? 4'd8 : p - 4'd1;
        return (p >= 8) ? 4'd1 : p + 4'd1;
    endfunction

    // Predict the status word that one accepted request produces.
    function automatic status_word_t predict_status(input req_t kind, input logic signed [15:0] a_in,
                                                    input logic signed [15:0] b_in);
        status_word_t s;
        longint a, b;
        logic ls, rs;
        a = a_in;
        b = b_in;
        ls = 1'b0;
        rs = 1'b0;
        case (kind)
            REQ_TICK: begin
                if (elapsed_l < COUNT_MAX) elapsed_l++;
                if (elapsed_r < COUNT_MAX) elapsed_r++;
                if (rps_l == 0) begin
                    coil_l = 4'h0;
                    period_l = 1000000;
                end else if (elapsed_l > period_l) begin
                    elapsed_l = 0;
                    coil_l = half_step_coils[phase_l];
                    phase_l = advance_phase(phase_l, rps_l < 0);
                    ls = 1'b1;
                end
                if (rps_r == 0) begin
                    coil_r = 4'h0;
                    period_r = 1000000;
                end else if (elapsed_r > period_r) begin
                    elapsed_r = 0;
                    coil_r = half_step_coils[phase_r];
                    phase_r = advance_phase(phase_r, rps_r > 0);
                    rs = 1'b1;
                end
            end
            REQ_VEL: begin
                if (magnitude(a) > vmax_q) begin
                    b = b * vmax_q / magnitude(a);
                    a = (a < 0) ? -vmax_q : vmax_q;
                end
                if (magnitude(b) > wmax_q) begin
                    a = a * wmax_q / magnitude(b);
                    b = (b < 0) ? -wmax_q : wmax_q;
                end
                speed_q = a;
                turn_q = b;
                load_wheel_speeds((5625 * a - 440 * b) / 2826, (5625 * a + 440 * b) / 2826);
            end
            REQ_RPS: load_wheel_speeds(a, b);
            default: ;
        endcase
        s.pad = '0;
        s.left_coils = coil_l;
        s.right_coils = coil_r;
        s.left_stepped = ls;
        s.right_stepped = rs;
        s.left_rps_now = rps_l[15:0];
        s.right_rps_now = rps_r[15:0];
        s.speed_now = speed_q[15:0];
        s.turn_now = turn_q[15:0];
        return s;
    endfunction

    // Send one request word, with bursts and random gaps on the sending side.
    task automatic send_request(input req_t kind, input logic [15:0] a, input logic [15:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            burst_left = $urandom_range(30, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        expected_status.push_back(predict_status(kind, a, b));
        words_sent++;
        if (kind == REQ_VEL || kind == REQ_RPS) commands_sent++;
    endtask

    // Let every outstanding result come back before touching registers.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limits(input longint vmax, input longint wmax, input longint rmax,
                              input longint steps);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_VMAX;
        cfg_wdata <= vmax[14:0];
        @(posedge aclk);
        vmax_q = vmax;
        cfg_addr <= CFG_WMAX;
        cfg_wdata <= wmax[14:0];
        @(posedge aclk);
        wmax_q = wmax;
        cfg_addr <= CFG_RMAX;
        cfg_wdata <= rmax[14:0];
        @(posedge aclk);
        rmax_q = rmax;
        cfg_addr <= CFG_STEPS;
        cfg_wdata <= {4'b0, steps[10:0]};
        @(posedge aclk);
        steps_q = steps & 11'h7FF;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(REQ_TICK, 16'($urandom), 16'($urandom));
    endtask

    // Reset values: commands under the default limits, including the extremes.
    task automatic test_default_limits;
        send_ticks(2);
        send_request(REQ_VEL, 16'h7FFF, 16'h0000);
        send_request(REQ_VEL, 16'h8000, 16'h7FFF);
        send_request(REQ_VEL, 16'd100, 16'h8000);
        send_request(REQ_VEL, 16'h0000, 16'h0000);
        send_request(REQ_RPS, 16'h7FFF, 16'h8000);
        send_request(REQ_NONE, 16'hFFFF, 16'hFFFF);
        send_request(REQ_RPS, 16'h0000, 16'h0000);
        send_ticks(2);
    endtask

    // Zero limits, the largest limits and a zero steps setting.
    task automatic test_limit_extremes;
        set_limits(0, 0, 0, 0);
        send_request(REQ_VEL, 16'h1234, 16'h8765);
        send_request(REQ_RPS, 16'h7FFF, 16'h0101);
        send_ticks(2);
        set_limits(32767, 32767, 32767, 0);
        send_request(REQ_VEL, 16'h7FFF, 16'h8000);
        send_request(REQ_RPS, 16'h8000, 16'h7FFF);
        send_ticks(3);
    endtask

    // Fast stepping both ways on both sides, then a stop of the left wheel that clears its coils.
    task automatic test_step_sequence;
        set_limits(32767, 32767, 32767, 1024);
        send_request(REQ_RPS, 16'h7FFF, 16'h8001);
        send_ticks(80);
        send_request(REQ_RPS, 16'h8001, 16'h7FFF);
        send_ticks(80);
        send_request(REQ_RPS, 16'h0000, 16'h4000);
        send_ticks(20);
    endtask

    // Random phases: mostly ticks with commands that keep the wheels stepping.
    task automatic test_random_traffic(input int n);
        int pick;
        logic [15:0] a, b;
        repeat (n) begin
            pick = $urandom_range(99);
            a = 16'($urandom);
            b = 16'($urandom);
            if (pick < 86) begin
                send_request(REQ_TICK, a, b);
            end else if (pick < 92) begin
                send_request(REQ_RPS, (pick & 1) ? a : {a[15], 15'h7F00 | a[14:0]},
                             (pick & 2) ? b : {b[15], 15'h7F00 | b[14:0]});
            end else if (pick < 98) begin
                send_request(REQ_VEL, a, b);
            end else begin
                send_request(REQ_NONE, a, b);
            end
        end
    endtask

    // Receiver stalls in random runs, with calm stretches in between.
    always @(posedge aclk) begin
        calm_cnt <= calm_cnt + 1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (calm_cnt[8] == 1'b0 && $urandom_range(5) == 0) begin
            stall_left <= $urandom_range(10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each returned status word with the oldest prediction.
    always @(posedge aclk) begin
        status_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (got.left_stepped || got.right_stepped) steps_seen++;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected status word %h", m_tdata);
            end else begin
                want = expected_status.pop_front();
                if (got.left_coils !== want.left_coils || got.right_coils !== want.right_coils ||
                    got.left_stepped !== want.left_stepped ||
                    got.right_stepped !== want.right_stepped ||
                    got.left_rps_now !== want.left_rps_now ||
                    got.right_rps_now !== want.right_rps_now ||
                    got.speed_now !== want.speed_now || got.turn_now !== want.turn_now ||
                    got.pad !== want.pad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d: expected coils %h/%h step %b/%b rps %0d/%0d v %0d w %0d",
                                 results_seen, want.left_coils, want.right_coils,
                                 want.left_stepped, want.right_stepped, want.left_rps_now,
                                 want.right_rps_now, want.speed_now, want.turn_now);
                        $display("word %0d: actual   coils %h/%h step %b/%b rps %0d/%0d v %0d w %0d",
                                 results_seen, got.left_coils, got.right_coils,
                                 got.left_stepped, got.right_stepped, got.left_rps_now,
                                 got.right_rps_now, got.speed_now, got.turn_now);
                    end
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_TICK;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_VMAX;
        cfg_wdata = '0;
        stall_left = 0;
        calm_cnt = 0;
        burst_left = 0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        steps_seen = 0;
        commands_sent = 0;
        vmax_q = 410;
        wmax_q = 5760;
        rmax_q = 1024;
        steps_q = 50;
        phase_l = 4'd1;
        phase_r = 4'd1;
        coil_l = 4'h0;
        coil_r = 4'h0;
        elapsed_l = 0;
        elapsed_r = 0;
        period_l = 1000000;
        period_r = 1000000;
        rps_l = 0;
        rps_r = 0;
        speed_q = 0;
        turn_q = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_limits();
        test_limit_extremes();
        test_step_sequence();
        set_limits(32767, 32767, 32767, 1024);
        test_random_traffic(400);
        set_limits(8000, 20000, 20000, 700);
        test_random_traffic(300);
        set_limits(410, 5760, 1024, 50);
        test_random_traffic(150);
        set_limits(32767, 32767, 32767, 1);
        test_random_traffic(80);
        set_limits(32767, 32767, 32767, 1024);
        test_random_traffic(200);
        drain();

        $display("Sent %0d words (%0d commands); %0d status words, %0d with a step.",
                 words_sent, commands_sent, results_seen, steps_seen);
        $display("Covered default, zero and full limits, and stepping in both directions.");
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_status.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/ddsc_pkg.sv
src/ddsc_div.sv
src/ddsc_datapath.sv
src/ddsc_ctrl.sv
src/diff_drive_stepper_controller_unit.sv
bench/tb.sv
